// File: rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define U16D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define U16D_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/u16d_pkg.sv
// Types and constants of the UTF-16 stream decoder.
`default_nettype none
package u16d_pkg;
    localparam int unsigned MaxResults = 3;
    localparam int unsigned QueueDepth = 4;

    localparam logic [5:0]  TagHigh   = 6'h36;
    localparam logic [5:0]  TagLow    = 6'h37;
    localparam logic [20:0] SuppBase  = 21'h10000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNPAIRED = 2'd1,
        ST_TRAILING = 2'd2,
        ST_DONE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [20:0] code_point;
        t_status     status;
    } t_result;

    typedef logic [1:0] t_count;

    // All results caused by one byte, slot 0 first.
    typedef struct packed {
        t_count                     count;
        t_result [MaxResults-1:0]   res;
    } t_bundle;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic head_valid;
    } t_queue_status;
endpackage
`default_nettype wire

// File: rtl/core/u16d_in_if.sv
// Byte input channel of the decoder.
`default_nettype none
interface u16d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/u16d_out_if.sv
// Result output channel of the decoder.
`default_nettype none
interface u16d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        last_result;

    modport source (output valid, output code_point, output status, output last_result,
                    input ready);
    modport sink   (input valid, input code_point, input status, input last_result,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/core/u16d_front.sv
// Front end: takes bytes, pairs units and surrogates, builds result bundles.
`default_nettype none
`include "assert_macros.svh"
module u16d_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire                     i_cfg_wdata,
    u16d_in_if.sink                 i_byte,
    input  u16d_pkg::t_queue_status i_qstat,
    output logic                    o_push,
    output u16d_pkg::t_bundle       o_bundle
);
    import u16d_pkg::*;

    logic        r_le;
    logic        r_byte_held, n_byte_held;
    logic [7:0]  r_held_byte, n_held_byte;
    logic        r_high_pending, n_high_pending;
    logic [9:0]  r_high_bits, n_high_bits;

    logic        accept;
    logic [15:0] unit;
    logic [5:0]  tag;
    logic        consumed;
    t_count      cnt;
    t_bundle     bundle;

    assign i_byte.ready = !i_qstat.full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign unit = r_le ? {i_byte.data_byte, r_held_byte} : {r_held_byte, i_byte.data_byte};
    assign tag  = unit[15:10];

    always_comb begin
        n_byte_held    = r_byte_held;
        n_held_byte    = r_held_byte;
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        consumed       = 1'b0;
        cnt            = '0;
        bundle         = '0;
        if (accept) begin
            if (!r_byte_held) begin
                n_byte_held = 1'b1;
                n_held_byte = i_byte.data_byte;
            end else begin
                n_byte_held = 1'b0;
                n_held_byte = '0;
                if (r_high_pending) begin
                    n_high_pending = 1'b0;
                    n_high_bits    = '0;
                    if (tag == TagLow) begin
                        bundle.res[cnt].code_point = {1'b0, r_high_bits, unit[9:0]} + SuppBase;
                        bundle.res[cnt].status     = ST_OK;
                        consumed = 1'b1;
                    end else begin
                        // emit the stranded high half raw
                        bundle.res[cnt].code_point = {5'd0, TagHigh, r_high_bits};
                        bundle.res[cnt].status     = ST_UNPAIRED;
                    end
                    cnt = cnt + 2'd1;
                end
                if (!consumed) begin
                    if (tag == TagHigh) begin
                        n_high_pending = 1'b1;
                        n_high_bits    = unit[9:0];
                    end else begin
                        bundle.res[cnt].code_point = {5'd0, unit};
                        bundle.res[cnt].status     = (tag == TagLow) ? ST_UNPAIRED : ST_OK;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            if (i_byte.last_byte) begin
                bundle.res[cnt].code_point = '0;
                bundle.res[cnt].status = (n_byte_held || n_high_pending) ? ST_TRAILING
                                                                         : ST_DONE;
                cnt = cnt + 2'd1;
                n_byte_held    = 1'b0;
                n_held_byte    = '0;
                n_high_pending = 1'b0;
                n_high_bits    = '0;
            end
        end
        bundle.count = cnt;
    end

    assign o_push   = accept && (cnt != '0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le           <= 1'b0;
            r_byte_held    <= 1'b0;
            r_held_byte    <= '0;
            r_high_pending <= 1'b0;
            r_high_bits    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_le <= i_cfg_wdata;
            end
            r_byte_held    <= n_byte_held;
            r_held_byte    <= n_held_byte;
            r_high_pending <= n_high_pending;
            r_high_bits    <= n_high_bits;
        end
    end

    `U16D_ASSERT(a_last_clears, i_clk, i_rst_n, (accept && i_byte.last_byte) |=> (!r_byte_held && !r_high_pending), "state not cleared after last byte")
    `U16D_NEVER(a_no_push_full, i_clk, i_rst_n, o_push && i_qstat.full, "bundle pushed into full queue")
endmodule
`default_nettype wire

// File: rtl/core/u16d_queue.sv
// Short bundle queue between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module u16d_queue #(
    parameter int unsigned Depth = u16d_pkg::QueueDepth
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  u16d_pkg::t_bundle       i_bundle,
    input  wire                     i_pop,
    output u16d_pkg::t_bundle       o_head,
    output u16d_pkg::t_queue_status o_qstat
);
    import u16d_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_bundle         r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    assign o_head             = r_mem[r_rd];
    assign o_qstat.full       = (r_count == CntW'(Depth));
    assign o_qstat.head_valid = (r_count != '0);

    `U16D_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")
endmodule
`default_nettype wire

// File: rtl/core/u16d_back.sv
// Back end: walks the head bundle and drives one result per beat.
`default_nettype none
`include "assert_macros.svh"
module u16d_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  u16d_pkg::t_bundle       i_head,
    input  u16d_pkg::t_queue_status i_qstat,
    output logic                    o_pop,
    u16d_out_if.source              o_char
);
    import u16d_pkg::*;

    t_count      r_idx;
    logic        r_valid;
    logic [20:0] r_cp;
    t_status     r_st;
    logic        r_last;

    logic        load;
    logic        idx_last;

    assign load     = i_qstat.head_valid && (!r_valid || o_char.ready);
    assign idx_last = (r_idx == i_head.count - 2'd1);
    assign o_pop    = load && idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= idx_last ? '0 : r_idx + 2'd1;
        end else if (o_char.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= i_head.res[r_idx].code_point;
            r_st   <= i_head.res[r_idx].status;
            r_last <= idx_last;
        end
    end

    assign o_char.valid       = r_valid;
    assign o_char.code_point  = r_cp;
    assign o_char.status      = r_st;
    assign o_char.last_result = r_last;

    `U16D_ASSERT(a_head_count, i_clk, i_rst_n, i_qstat.head_valid |-> (i_head.count != '0 && r_idx < i_head.count), "bad bundle count or index")
    `U16D_ASSERT(a_idx_rewinds, i_clk, i_rst_n, o_pop |=> (r_idx == '0), "index not rewound after pop")
endmodule
`default_nettype wire

// File: rtl/core/utf16_stream_decoder_unit.sv
// UTF-16 stream decoder: byte channel in, code point channel out.
//
// Usage: bytes of a UTF-16 string arrive on i_byte, one per beat, with
// last_byte on the final byte. i_cfg_we/i_cfg_wdata set the byte order
// (0 big-endian, 1 little-endian); write it only while the block is idle.
// Each byte yields zero to three results on o_char: code points with status
// ok, raw unpaired surrogates, then done or trailing data on the last byte.
// last_result marks the final result caused by a byte.
// The queue stores the bundle at the edge that takes the byte, and the output
// register loads it from the queue head once earlier results have gone out.
// Throughput: one byte per cycle; o_char delivers one result per cycle, so
// a byte causing two or three results holds the output for that many beats.
// A queue of QueueDepth bundles between front and back absorbs this; the
// front stalls only when that queue is full.
// Reset clears the held byte, the pending high surrogate, the queue and the
// output valid flag, and selects big-endian order. When the receiver stalls,
// the output holds and the queue fills before i_byte.ready drops.
`default_nettype none
module utf16_stream_decoder_unit #(
    parameter int unsigned QueueDepth = u16d_pkg::QueueDepth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    u16d_in_if.sink     i_byte,
    u16d_out_if.source  o_char
);
    import u16d_pkg::*;

    logic          push;
    logic          pop;
    t_bundle       bundle;
    t_bundle       head;
    t_queue_status qstat;

    u16d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_byte),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_bundle    (bundle)
    );

    u16d_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_qstat  (qstat)
    );

    u16d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_char  (o_char)
    );
endmodule
`default_nettype wire
